// File: hdl/dmdff_pkg.sv
// shared constants for the dot-matrix frame fitter
// palette tables, output geometry and register indexes; no dependencies
`default_nettype none

package dmdff_pkg;

  // output frame geometry
  localparam int OUT_WIDTH     = 128;
  localparam int OUT_HEIGHT    = 32;
  localparam int MAX_SRC_WIDTH = 256;

  // pair-sum line buffer
  localparam int LINE_DEPTH = 128;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int PAIR_W     = 5;

  // configuration register indexes
  localparam logic [1:0] CFG_SRC_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd2;

  // pixel formats
  localparam logic [1:0] FMT_SHADE2 = 2'd0;
  localparam logic [1:0] FMT_SHADE4 = 2'd1;

  // two-bit shade to level
  localparam logic [3:0] SHADE2_LEVEL [4] = '{4'd0, 4'd1, 4'd4, 4'd15};

  // level * 0xff / 0xf
  localparam logic [7:0] RED_LUT [16] = '{
    8'd0,   8'd17,  8'd34,  8'd51,  8'd68,  8'd85,  8'd102, 8'd119,
    8'd136, 8'd153, 8'd170, 8'd187, 8'd204, 8'd221, 8'd238, 8'd255
  };

  // level * 0x45 / 0xf, rounded down
  localparam logic [7:0] GREEN_LUT [16] = '{
    8'd0,  8'd4,  8'd9,  8'd13, 8'd18, 8'd23, 8'd27, 8'd32,
    8'd36, 8'd41, 8'd46, 8'd50, 8'd55, 8'd59, 8'd64, 8'd69
  };

endpackage

`default_nettype wire

// File: hdl/dmdff_pair_line.sv
// line buffer of horizontal pair sums for the 2x downscale
// one write and one registered read per cycle; widths from dmdff_pkg
`default_nettype none

module dmdff_pair_line #(
  parameter int ADDR_W = dmdff_pkg::LINE_AW,
  parameter int DATA_W = dmdff_pkg::PAIR_W
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/dmd_frame_fit_128x32_top.sv
// top level of the dot-matrix frame fitter into a 128x32 orange-red frame
// uses dmdff_pkg and the pair-sum line buffer dmdff_pair_line
`default_nettype none

// Takes one luminance pixel per cycle in raster order and turns it into at most
// one pixel write of the 128x32 output frame. A 128x32 source is copied
// straight through, a 128-wide source with fewer than 32 rows is centred
// vertically, and a source 64 rows high and up to 256 wide is averaged over
// 2x2 blocks ((sum+2)>>2) and centred horizontally; anything else, or
// pixel format 2 or 3, counts pixels but writes nothing. frame_start on a pixel
// restarts the raster position; pixels after the last one of a frame are
// dropped until the next frame_start. Throughput is one pixel per cycle while
// the output is not stalled: each pixel costs at most one access to the 128-entry
// pair-sum line buffer (a write on even source rows, a read on odd ones), so the
// buffer never holds pixels back. A write word passes through the read stage,
// alongside the buffer read, and then through the output register. With the
// output stalled the block still takes pixels until one that makes a write
// waits in the read stage; pixels that make no write keep flowing until then.
// Configuration is only to be written with the pipe empty. The line buffer is
// not cleared; in downscale mode the first row pair of a frame fills it.

module dmd_frame_fit_128x32_top (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  // pixel words in
  input  wire logic       pixel_valid,
  output      logic       pixel_ready,
  input  wire logic [3:0] pixel_value,
  input  wire logic       frame_start,
  // write words out
  output      logic       write_valid,
  input  wire logic       write_ready,
  output      logic [11:0] write_address,
  output      logic [7:0] red,
  output      logic [7:0] green,
  output      logic [7:0] blue,
  output      logic       frame_last
);

  localparam int AW = dmdff_pkg::LINE_AW;
  localparam int PW = dmdff_pkg::PAIR_W;

  // configuration registers
  logic [8:0] src_width;
  logic [6:0] src_height;
  logic [1:0] pixel_format;

  // raster state
  logic [7:0] column_count;
  logic [5:0] row_count;
  logic [3:0] held_pixel;
  logic       frame_done;

  // read stage
  logic          s1_valid;
  logic [11:0]   s1_addr;
  logic          s1_last;
  logic          s1_use_sum;
  logic [3:0]    s1_level;
  logic [PW-1:0] s1_pair;
  logic          s1_fmt4;
  logic [PW-1:0] line_rd;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= 9'(dmdff_pkg::OUT_WIDTH);
      src_height   <= 7'(dmdff_pkg::OUT_HEIGHT);
      pixel_format <= dmdff_pkg::FMT_SHADE2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmdff_pkg::CFG_SRC_WIDTH:    src_width    <= cfg_data;
        dmdff_pkg::CFG_SRC_HEIGHT:   src_height   <= cfg_data[6:0];
        dmdff_pkg::CFG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // front: raster position and mode decode
  // ---------------------------------------------------------------------------
  logic       accept;
  logic       s1_adv;
  logic [7:0] col;
  logic [5:0] row;
  logic       done_eff;
  logic [3:0] pix;
  logic       fmt_ok;
  logic       mode_copy, mode_ctr, mode_down;
  logic [8:0] col_plus;
  logic [6:0] row_plus;
  logic       col_end, row_end;
  logic [8:0] w_even;
  logic       pair_ok;
  logic       live;
  logic       emit;
  logic       line_wr, line_rd_en;
  logic [PW-1:0] pair;
  logic [5:0] ctr_ofs_full;
  logic [4:0] ctr_row;
  logic [7:0] ofsx_full;
  logic [6:0] x;
  logic [11:0] addr_copy, addr_ctr, addr_down;
  logic       last_copy, last_ctr, last_down;
  logic [11:0] emit_addr;
  logic       emit_last;

  assign s1_adv      = s1_valid && (!write_valid || write_ready);
  assign pixel_ready = !s1_valid || s1_adv;
  assign accept      = pixel_valid && pixel_ready;

  // frame_start restarts the position before the pixel is placed
  assign col      = frame_start ? 8'd0 : column_count;
  assign row      = frame_start ? 6'd0 : row_count;
  assign done_eff = frame_start ? 1'b0 : frame_done;
  assign live     = accept && !done_eff;

  // two-bit shades keep their low bits only
  assign pix = (pixel_format == dmdff_pkg::FMT_SHADE2) ? {2'd0, pixel_value[1:0]} : pixel_value;

  assign fmt_ok    = (pixel_format == dmdff_pkg::FMT_SHADE2) ||
                     (pixel_format == dmdff_pkg::FMT_SHADE4);
  assign mode_copy = fmt_ok && (src_width == 9'(dmdff_pkg::OUT_WIDTH)) &&
                     (src_height == 7'(dmdff_pkg::OUT_HEIGHT));
  assign mode_ctr  = fmt_ok && (src_width == 9'(dmdff_pkg::OUT_WIDTH)) &&
                     (src_height < 7'(dmdff_pkg::OUT_HEIGHT));
  assign mode_down = fmt_ok && (src_width <= 9'(dmdff_pkg::MAX_SRC_WIDTH)) &&
                     (src_height == 7'(2 * dmdff_pkg::OUT_HEIGHT));

  // raster advance; counters also stop at their own full range
  assign col_plus = {1'b0, col} + 9'd1;
  assign row_plus = {1'b0, row} + 7'd1;
  assign col_end  = (col_plus >= src_width) || (col == 8'hFF);
  assign row_end  = (row_plus >= src_height) || (row == 6'h3F);

  // downscale: odd column closes a pair, an odd trailing column is dropped
  assign w_even  = {src_width[8:1], 1'b0};
  assign pair_ok = col[0] && ({1'b0, col} < w_even);
  assign pair    = PW'({1'b0, held_pixel} + {1'b0, pix});
  assign x       = col[7:1];

  assign line_wr    = live && mode_down && pair_ok && !row[0];
  assign line_rd_en = live && mode_down && pair_ok && row[0];
  assign emit       = live && (mode_copy || mode_ctr || (mode_down && pair_ok && row[0]));

  // straight copy
  assign addr_copy = {row[4:0], 7'd0} + {4'd0, col};
  assign last_copy = (row == 6'(dmdff_pkg::OUT_HEIGHT - 1)) &&
                     (col == 8'(dmdff_pkg::OUT_WIDTH - 1));

  // vertical centring, offset (32 - h) / 2
  assign ctr_ofs_full = 6'(dmdff_pkg::OUT_HEIGHT) - {1'b0, src_height[4:0]};
  assign ctr_row      = ctr_ofs_full[5:1] + row[4:0];
  assign addr_ctr     = {ctr_row, 7'd0} + {4'd0, col};
  assign last_ctr     = (row_plus == src_height) && (col == 8'(dmdff_pkg::OUT_WIDTH - 1));

  // horizontal centring in downscale, offset (128 - w/2) / 2
  assign ofsx_full = 8'(dmdff_pkg::OUT_WIDTH) - src_width[8:1];
  assign addr_down = {row[5:1], 7'd0} + {5'd0, ofsx_full[7:1]} + {5'd0, x};
  assign last_down = (row == 6'(2 * dmdff_pkg::OUT_HEIGHT - 1)) && (col_plus == w_even);

  always_comb begin
    priority if (mode_copy) begin
      emit_addr = addr_copy;
      emit_last = last_copy;
    end else if (mode_ctr) begin
      emit_addr = addr_ctr;
      emit_last = last_ctr;
    end else begin
      emit_addr = addr_down;
      emit_last = last_down;
    end
  end

  // a live pixel always clears frame_done unless it closes the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
      frame_done   <= 1'b0;
    end else if (accept) begin
      if (!done_eff) begin
        if (col_end) begin
          column_count <= '0;
          if (row_end) begin
            row_count  <= row;
            frame_done <= 1'b1;
          end else begin
            row_count  <= row_plus[5:0];
            frame_done <= 1'b0;
          end
        end else begin
          column_count <= col_plus[7:0];
          row_count    <= row;
          frame_done   <= 1'b0;
        end
        if (mode_down && !col[0]) begin
          held_pixel <= pix;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pair-sum line buffer: written on even rows, read on odd rows
  // ---------------------------------------------------------------------------
  dmdff_pair_line #(
    .ADDR_W (AW),
    .DATA_W (PW)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (x[AW-1:0]),
    .wr_data (pair),
    .rd_en   (line_rd_en),
    .rd_addr (x[AW-1:0]),
    .rd_data (line_rd)
  );

  // ---------------------------------------------------------------------------
  // read stage, waits alongside the line buffer read
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= emit || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_addr    <= emit_addr;
      s1_last    <= emit_last;
      s1_use_sum <= !(mode_copy || mode_ctr);
      s1_level   <= pix;
      s1_pair    <= pair;
      s1_fmt4    <= (pixel_format == dmdff_pkg::FMT_SHADE4);
    end
  end

  // ---------------------------------------------------------------------------
  // 2x2 average, palette and output register
  // ---------------------------------------------------------------------------
  logic [6:0] sum_rnd;
  logic [3:0] level;
  logic [3:0] pal_idx;

  assign sum_rnd = {2'd0, line_rd} + {2'd0, s1_pair} + 7'd2;
  assign level   = s1_use_sum ? sum_rnd[5:2] : s1_level;
  assign pal_idx = s1_fmt4 ? level : dmdff_pkg::SHADE2_LEVEL[level[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      write_valid <= 1'b0;
    end else if (s1_adv) begin
      write_valid <= 1'b1;
    end else if (write_ready) begin
      write_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      write_address <= s1_addr;
      red           <= dmdff_pkg::RED_LUT[pal_idx];
      green         <= dmdff_pkg::GREEN_LUT[pal_idx];
      frame_last    <= s1_last;
    end
  end

  // the palette has no blue
  assign blue = 8'd0;

endmodule

`default_nettype wire

// File: hdl/dmdff_checker.sv
// port-level checks for the dot-matrix frame fitter
// bound to dmd_frame_fit_128x32_top; no package dependencies
`default_nettype none

module dmdff_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pixel_valid,
  input wire logic        pixel_ready,
  input wire logic        write_valid,
  input wire logic        write_ready,
  input wire logic [11:0] write_address,
  input wire logic [7:0]  red,
  input wire logic [7:0]  green,
  input wire logic [7:0]  blue
);

  // a fresh write word follows a pixel word taken earlier, which passed through the read stage and the output register
  a_word_follows_pixel: assert property (@(posedge clk) disable iff (rst)
    $rose(write_valid) |-> $past(pixel_valid && pixel_ready, 2))
    else $error("write word without a pixel word taken two cycles earlier");

  // the palette is orange-red: red and green are dark together, blue never lit
  a_palette_shape: assert property (@(posedge clk) disable iff (rst)
    write_valid |-> ((red == 8'd0) == (green == 8'd0)) && (blue == 8'd0))
    else $error("colour outside the orange-red palette");

  // the pipe is empty straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !write_valid)
    else $error("write word present right after reset");

  // a stalled write word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    write_valid && !write_ready |=> write_valid && $stable(write_address) &&
                                    $stable(red) && $stable(green))
    else $error("stalled write word changed");

endmodule

bind dmd_frame_fit_128x32_top dmdff_checker u_dmdff_checker (
  .clk           (clk),
  .rst           (rst),
  .pixel_valid   (pixel_valid),
  .pixel_ready   (pixel_ready),
  .write_valid   (write_valid),
  .write_ready   (write_ready),
  .write_address (write_address),
  .red           (red),
  .green         (green),
  .blue          (blue)
);

`default_nettype wire
